// ===== sv/memory_change_watch_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the change watch table
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEMORY_CHANGE_WATCH_TABLE_UNIT_ASSERT_SVH
`define MEMORY_CHANGE_WATCH_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// expression must hold at every edge
`define MCW_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define MCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCW_ASSERT_ALWAYS(label, expr, msg)
`define MCW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/mcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Change watch table package
// Beat types, opcodes and status codes shared by the watch table files.
// ----------------------------------------------------------------------------
package mcw_pkg;

    // opcodes
    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_QUERY  = 3'd2;
    localparam logic [2:0] OP_SAMPLE = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    localparam int REV_W  = 32;
    localparam int ADDR_W = 32;
    localparam int CTR_W  = 64;

    // request beat
    typedef struct packed {
        logic [2:0]        opcode;
        logic [7:0]        slot_id;
        logic [ADDR_W-1:0] region_start;
        logic [7:0]        region_length;
        logic [5:0]        byte_offset;
        logic [7:0]        sample_byte;
    } mcw_in_t;

    // result beat
    typedef struct packed {
        logic              status;
        logic [3:0]        assigned_slot;
        logic [REV_W-1:0]  revision_count;
        logic [ADDR_W-1:0] watched_start;
        logic [6:0]        watched_length;
        logic [4:0]        active_watches;
        logic [CTR_W-1:0]  total_compares;
        logic [CTR_W-1:0]  total_changes;
        logic              region_done;
        logic              region_changed;
    } mcw_out_t;

endpackage

// ===== sv/mcw_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface mcw_in_if;
    import mcw_pkg::*;

    logic    valid;
    logic    ready;
    mcw_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mcw_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface mcw_out_if;
    import mcw_pkg::*;

    logic     valid;
    logic     ready;
    mcw_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/memory_change_watch_table_unit.sv =====
// ----------------------------------------------------------------------------
// Memory change watch table
// Table of region watches with a per-slot shadow copy and change counting.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries request beats (add, remove, query, sample byte, clear all);
//   out_ch returns exactly one result beat per request, in order.
//   Each request passes S_IDLE and S_EXEC: on accept in S_IDLE the slot RAM
//   (revision, start, length) and the shadow RAM are read; S_EXEC then
//   modifies, writes both RAMs back and loads the result register. No new
//   request is taken until S_EXEC is left, due to that read-modify-write on
//   the RAMs, and the result is registered in out_reg.
//   in_ch.ready is high whenever no request is in flight, so a new request
//   is taken while an earlier result still waits in the output register.
//   If the receiver stalls, the result is held; the next request is read
//   and then waits until the output register frees.
//   Reset clears live and primed bits, counters and the pass flag at once;
//   the slot RAM needs no clearing pass since every live entry is written by add.
// ----------------------------------------------------------------------------
`include "memory_change_watch_table_unit_assert.svh"

module memory_change_watch_table_unit #(
    parameter int SLOTS       = 16,
    parameter int WATCH_BYTES = 64
) (
    input logic        clk,
    input logic        rst_n,
    mcw_in_if.sink     in_ch,
    mcw_out_if.source  out_ch
);
    import mcw_pkg::*;

    localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int LEN_W     = $clog2(WATCH_BYTES + 1);
    localparam int WORD_W    = REV_W + ADDR_W + LEN_W;
    localparam int SH_DEPTH  = SLOTS * WATCH_BYTES;
    localparam int SH_AW     = (SH_DEPTH > 1) ? $clog2(SH_DEPTH) : 1;
    localparam int SH_FULL_W = SH_AW + 9;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t               state_reg, state_next;
    mcw_in_t              item_reg, item_next;
    logic [SH_AW-1:0]     sh_addr_reg, sh_addr_next;
    logic [SLOTS-1:0]     live_reg, live_next;
    logic [SLOTS-1:0]     primed_reg, primed_next;
    logic [CNT_W-1:0]     live_total_reg, live_total_next;
    logic [CTR_W-1:0]     cmp_reg, cmp_next;
    logic [CTR_W-1:0]     chg_reg, chg_next;
    logic                 differs_reg, differs_next;
    logic                 out_valid_reg, out_valid_next;
    mcw_out_t             out_reg, out_next;

    logic                 accept;
    logic                 fire;
    logic [SH_FULL_W-1:0] sh_addr_full;

    logic                 slot_we;
    logic [SW-1:0]        slot_waddr;
    logic [WORD_W-1:0]    slot_wdata;
    logic [WORD_W-1:0]    slot_rdata;
    logic                 sh_we;
    logic [7:0]           sh_rdata;

    logic                 free_found;
    logic [SW-1:0]        free_idx;

    logic [SW-1:0]        slot_idx;
    logic                 slot_ok;
    logic [REV_W-1:0]     rd_rev;
    logic [ADDR_W-1:0]    rd_start;
    logic [LEN_W-1:0]     rd_len;
    logic                 len_ok;
    logic                 off_ok;
    logic                 off_last;
    logic                 differs_now;
    mcw_out_t             res;

    // handshake
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign accept       = in_ch.valid && (state_reg == S_IDLE);
    assign fire         = (state_reg == S_EXEC) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // shadow address of the incoming beat
    assign sh_addr_full = SH_FULL_W'(in_ch.data.slot_id) * SH_FULL_W'(WATCH_BYTES)
                        + SH_FULL_W'(in_ch.data.byte_offset);

    // slot RAM: {revision, start, length}
    mcw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (accept),
        .raddr (in_ch.data.slot_id[SW-1:0]),
        .rdata (slot_rdata)
    );

    // shadow byte RAM
    mcw_ram #(
        .WIDTH (8),
        .DEPTH (SH_DEPTH)
    ) u_shadow_ram (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_addr_reg),
        .wdata (item_reg.sample_byte),
        .re    (accept),
        .raddr (sh_addr_full[SH_AW-1:0]),
        .rdata (sh_rdata)
    );

    mcw_free_find #(
        .SLOTS (SLOTS),
        .SW    (SW)
    ) u_free_find (
        .live  (live_reg),
        .found (free_found),
        .idx   (free_idx)
    );

    // decode of the request in flight
    assign slot_idx    = item_reg.slot_id[SW-1:0];
    assign slot_ok     = ({1'b0, item_reg.slot_id} < 9'(SLOTS)) && live_reg[slot_idx];
    assign rd_rev      = slot_rdata[WORD_W-1 -: REV_W];
    assign rd_start    = slot_rdata[LEN_W +: ADDR_W];
    assign rd_len      = slot_rdata[LEN_W-1:0];
    assign len_ok      = (item_reg.region_length != 8'd0)
                      && (16'(item_reg.region_length) <= 16'(WATCH_BYTES));
    assign off_ok      = 16'(item_reg.byte_offset) < 16'(rd_len);
    assign off_last    = (16'(item_reg.byte_offset) + 16'd1) == 16'(rd_len);
    assign differs_now = primed_reg[slot_idx] && (sh_rdata != item_reg.sample_byte);

    // next state and write-back
    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        sh_addr_next    = sh_addr_reg;
        live_next       = live_reg;
        primed_next     = primed_reg;
        live_total_next = live_total_reg;
        cmp_next        = cmp_reg;
        chg_next        = chg_reg;
        differs_next    = differs_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_next        = out_reg;
        slot_we         = 1'b0;
        slot_waddr      = slot_idx;
        slot_wdata      = {rd_rev + 32'd1, rd_start, rd_len};
        sh_we           = 1'b0;
        res             = '0;
        res.status      = STATUS_REFUSED;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    item_next    = in_ch.data;
                    sh_addr_next = sh_addr_full[SH_AW-1:0];
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    unique case (item_reg.opcode)
                        OP_ADD:
                        begin
                            if (len_ok && free_found)
                            begin
                                live_next[free_idx]   = 1'b1;
                                primed_next[free_idx] = 1'b0;
                                live_total_next       = live_total_reg + CNT_W'(1);
                                slot_we               = 1'b1;
                                slot_waddr            = free_idx;
                                slot_wdata            = {{REV_W{1'b0}}, item_reg.region_start,
                                                         LEN_W'(item_reg.region_length)};
                                res.status            = STATUS_OK;
                                res.assigned_slot     = 4'(free_idx);
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                live_next[slot_idx]   = 1'b0;
                                primed_next[slot_idx] = 1'b0;
                                live_total_next       = live_total_reg - CNT_W'(1);
                                res.status            = STATUS_OK;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (slot_ok)
                            begin
                                res.status         = STATUS_OK;
                                res.revision_count = rd_rev;
                                res.watched_start  = rd_start;
                                res.watched_length = 7'(rd_len);
                            end
                        end
                        OP_SAMPLE:
                        begin
                            if (slot_ok && off_ok)
                            begin
                                res.status = STATUS_OK;
                                sh_we      = 1'b1;
                                if (off_last)
                                begin
                                    res.region_done = 1'b1;
                                    cmp_next        = cmp_reg + 64'd1;
                                    if (!primed_reg[slot_idx])
                                    begin
                                        primed_next[slot_idx] = 1'b1;
                                    end
                                    else if (differs_reg || differs_now)
                                    begin
                                        slot_we            = 1'b1;
                                        chg_next           = chg_reg + 64'd1;
                                        res.region_changed = 1'b1;
                                    end
                                    differs_next = 1'b0;
                                end
                                else
                                begin
                                    differs_next = differs_reg || differs_now;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            live_next       = '0;
                            primed_next     = '0;
                            live_total_next = '0;
                            cmp_next        = '0;
                            chg_next        = '0;
                            differs_next    = 1'b0;
                            res.status      = STATUS_OK;
                        end
                        default:
                        begin
                            // unused opcodes are refused
                        end
                    endcase
                    res.active_watches = 5'(live_total_next);
                    res.total_compares = cmp_next;
                    res.total_changes  = chg_next;
                    out_next           = res;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            sh_addr_reg    <= '0;
            live_reg       <= '0;
            primed_reg     <= '0;
            live_total_reg <= '0;
            cmp_reg        <= '0;
            chg_reg        <= '0;
            differs_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            item_reg       <= item_next;
            sh_addr_reg    <= sh_addr_next;
            live_reg       <= live_next;
            primed_reg     <= primed_next;
            live_total_reg <= live_total_next;
            cmp_reg        <= cmp_next;
            chg_reg        <= chg_next;
            differs_reg    <= differs_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    // checks
    `MCW_ASSERT_ALWAYS(a_live_count, 32'(live_total_reg) == 32'($countones(live_reg)), "live count mismatch")
    `MCW_ASSERT_ALWAYS(a_primed_live, (primed_reg & ~live_reg) == '0, "primed bit on dead slot")
    `MCW_ASSERT_NEXT(a_out_from_exec, !out_valid_reg && (state_reg != S_EXEC), !out_valid_reg, "result without execute")

endmodule

// ===== sv/mcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/mcw_free_find.sv =====
// ----------------------------------------------------------------------------
// Free slot finder
// Priority encoder giving the lowest slot whose live bit is clear.
// ----------------------------------------------------------------------------
module mcw_free_find #(
    parameter int SLOTS = 16,
    parameter int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0] live,
    output logic             found,
    output logic [SW-1:0]    idx
);

    // scan from the top so the lowest free slot wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!live[i])
            begin
                found = 1'b1;
                idx   = SW'(i);
            end
        end
    end

endmodule

// ===== test/mcw_watch_checker.sv =====
// ----------------------------------------------------------------------------
// Change watch table checker
// Watches both channels, predicts the result of every accepted request beat
// from its own copy of the watch table, and compares each result beat field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mcw_watch_checker #(
    parameter int SLOTS       = 16,
    parameter int WATCH_BYTES = 64
) (
    input  logic clk,
    input  logic rst_n,
    mcw_in_if    req_ch,
    mcw_out_if   res_ch,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcw_pkg::*;

    // predicted table state
    logic              watch_live   [SLOTS];
    logic              watch_primed [SLOTS];
    logic [REV_W-1:0]  watch_rev    [SLOTS];
    logic [ADDR_W-1:0] watch_start  [SLOTS];
    logic [6:0]        watch_len    [SLOTS];
    logic [7:0]        shadow_bytes [SLOTS*WATCH_BYTES];
    logic              pass_dirty;
    logic [4:0]        live_count;
    logic [CTR_W-1:0]  compare_total;
    logic [CTR_W-1:0]  change_total;

    mcw_out_t predicted_beats [$];
    mcw_out_t oldest_beat;
    int       error_total;

    // kill every watch, zero the revisions and counters; starts, lengths and shadow bytes stay
    function automatic void clear_watches();
        for (int i = 0; i < SLOTS; i++)
        begin
            watch_live[i]   = 1'b0;
            watch_primed[i] = 1'b0;
            watch_rev[i]    = '0;
        end
        pass_dirty    = 1'b0;
        live_count    = '0;
        compare_total = '0;
        change_total  = '0;
    endfunction

    // apply one request to the predicted table and return its result beat
    function automatic mcw_out_t predict_watch_result(mcw_in_t req);
        mcw_out_t res;
        logic     named_live;
        logic     placed;
        int       idx;
        int       byte_pos;
        res        = '0;
        res.status = STATUS_REFUSED;
        idx        = int'(req.slot_id);
        named_live = (idx < SLOTS) ? watch_live[idx] : 1'b0;
        placed     = 1'b0;
        case (req.opcode)
            OP_ADD:
            begin
                if (req.region_length != 0 && req.region_length <= WATCH_BYTES)
                begin
                    // lowest free slot wins
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!placed && !watch_live[i])
                        begin
                            watch_live[i]     = 1'b1;
                            watch_primed[i]   = 1'b0;
                            watch_rev[i]      = '0;
                            watch_start[i]    = req.region_start;
                            watch_len[i]      = 7'(req.region_length);
                            live_count        = live_count + 5'd1;
                            res.status        = STATUS_OK;
                            res.assigned_slot = 4'(i);
                            placed            = 1'b1;
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                if (named_live)
                begin
                    watch_live[idx]   = 1'b0;
                    watch_primed[idx] = 1'b0;
                    live_count        = live_count - 5'd1;
                    res.status        = STATUS_OK;
                end
            end
            OP_QUERY:
            begin
                if (named_live)
                begin
                    res.status         = STATUS_OK;
                    res.revision_count = watch_rev[idx];
                    res.watched_start  = watch_start[idx];
                    res.watched_length = watch_len[idx];
                end
            end
            OP_SAMPLE:
            begin
                if (named_live && req.byte_offset < watch_len[idx])
                begin
                    byte_pos   = idx * WATCH_BYTES + int'(req.byte_offset);
                    res.status = STATUS_OK;
                    // the priming pass only fills the shadow
                    if (watch_primed[idx] && shadow_bytes[byte_pos] != req.sample_byte)
                        pass_dirty = 1'b1;
                    shadow_bytes[byte_pos] = req.sample_byte;
                    // last byte of the region closes the pass
                    if (int'(req.byte_offset) + 1 == int'(watch_len[idx]))
                    begin
                        res.region_done = 1'b1;
                        compare_total   = compare_total + 1'b1;
                        if (!watch_primed[idx])
                            watch_primed[idx] = 1'b1;
                        else if (pass_dirty)
                        begin
                            watch_rev[idx]     = watch_rev[idx] + 1'b1;
                            change_total       = change_total + 1'b1;
                            res.region_changed = 1'b1;
                        end
                        pass_dirty = 1'b0;
                    end
                end
            end
            OP_CLEAR:
            begin
                clear_watches();
                res.status = STATUS_OK;
            end
            default:
            begin
            end
        endcase
        res.active_watches = live_count;
        res.total_compares = compare_total;
        res.total_changes  = change_total;
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_total++;
        end
    endtask

    // result beats are compared before the request beat of the same edge is
    // predicted: a result never belongs to a request taken at that edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_watches();
            for (int i = 0; i < SLOTS; i++)
            begin
                watch_start[i] = '0;
                watch_len[i]   = '0;
            end
            for (int i = 0; i < SLOTS * WATCH_BYTES; i++)
                shadow_bytes[i] = '0;
            predicted_beats.delete();
            error_total = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (predicted_beats.size() == 0)
                begin
                    $error("result beat with no request waiting");
                    error_total++;
                end
                else
                begin
                    oldest_beat = predicted_beats.pop_front();
                    check_field("status", oldest_beat.status, res_ch.data.status);
                    check_field("assigned_slot", oldest_beat.assigned_slot,
                                res_ch.data.assigned_slot);
                    check_field("revision_count", oldest_beat.revision_count,
                                res_ch.data.revision_count);
                    check_field("watched_start", oldest_beat.watched_start,
                                res_ch.data.watched_start);
                    check_field("watched_length", oldest_beat.watched_length,
                                res_ch.data.watched_length);
                    check_field("active_watches", oldest_beat.active_watches,
                                res_ch.data.active_watches);
                    check_field("total_compares", oldest_beat.total_compares,
                                res_ch.data.total_compares);
                    check_field("total_changes", oldest_beat.total_changes,
                                res_ch.data.total_changes);
                    check_field("region_done", oldest_beat.region_done,
                                res_ch.data.region_done);
                    check_field("region_changed", oldest_beat.region_changed,
                                res_ch.data.region_changed);
                end
            end
            if (req_ch.valid && req_ch.ready)
                predicted_beats.insert(predicted_beats.size(),
                                       predict_watch_result(req_ch.data));
        end
        mismatches  <= error_total;
        outstanding <= predicted_beats.size();
    end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Change watch table testbench
// Drives request beats into the watch table: a directed opening over the
// refusal and pass cases, a table fill, then random full passes mixed with
// adds, removes, queries, stray samples, clears and unused opcodes, under several idle and
// stall patterns. The checker beside the block scores every result beat.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import mcw_pkg::*;

    localparam int SLOTS        = 16;
    localparam int WATCH_BYTES  = 64;
    localparam int RANDOM_ITEMS = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   outstanding;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   counted_items;

    // sender-side view of the table, kept only to form legal passes
    logic       slot_live   [SLOTS];
    logic       slot_primed [SLOTS];
    int         slot_len    [SLOTS];
    logic       byte_seen   [SLOTS][WATCH_BYTES];
    logic [7:0] mem_image   [SLOTS][WATCH_BYTES];

    mcw_in_if  in_ch ();
    mcw_out_if out_ch ();

    memory_change_watch_table_unit #(
        .SLOTS       (SLOTS),
        .WATCH_BYTES (WATCH_BYTES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    mcw_watch_checker #(
        .SLOTS       (SLOTS),
        .WATCH_BYTES (WATCH_BYTES)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_ch      (in_ch),
        .res_ch      (out_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("** memory_change_watch_table_unit: FAILED **");
        $finish;
    end

    function automatic mcw_in_t beat_of(logic [2:0] op, logic [7:0] slot,
                                        logic [31:0] start, logic [7:0] len,
                                        logic [5:0] off, logic [7:0] data);
        mcw_in_t beat;
        beat.opcode        = op;
        beat.slot_id       = slot;
        beat.region_start  = start;
        beat.region_length = len;
        beat.byte_offset   = off;
        beat.sample_byte   = data;
        return beat;
    endfunction

    // random content in every field, the opcode given
    function automatic mcw_in_t noise_beat(logic [2:0] op);
        return beat_of(op, 8'($urandom), $urandom, 8'($urandom), 6'($urandom),
                       8'($urandom));
    endfunction

    function automatic logic [7:0] random_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return 8'($urandom_range(1, 8));
        if (pick < 85)
            return 8'($urandom_range(9, WATCH_BYTES - 1));
        if (pick < 90)
            return 8'(WATCH_BYTES);
        if (pick < 95)
            return 8'd0;
        return 8'($urandom_range(WATCH_BYTES + 1, 255));
    endfunction

    function automatic int pick_live_slot();
        int found [$];
        for (int i = 0; i < SLOTS; i++)
            if (slot_live[i])
                found.insert(found.size(), i);
        if (found.size() == 0)
            return -1;
        return found[$urandom_range(0, found.size() - 1)];
    endfunction

    // follow live, primed and written bytes as the block will see them
    function automatic void track_request(mcw_in_t beat);
        int  idx;
        int  off;
        logic placed;
        idx    = int'(beat.slot_id);
        off    = int'(beat.byte_offset);
        placed = 1'b0;
        case (beat.opcode)
            OP_ADD:
            begin
                if (beat.region_length != 0 && beat.region_length <= WATCH_BYTES)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!placed && !slot_live[i])
                        begin
                            slot_live[i]   = 1'b1;
                            slot_primed[i] = 1'b0;
                            slot_len[i]    = int'(beat.region_length);
                            placed         = 1'b1;
                        end
                    end
                end
            end
            OP_REMOVE:
            begin
                if (idx < SLOTS)
                    slot_live[idx] = 1'b0;
            end
            OP_SAMPLE:
            begin
                if (idx < SLOTS && slot_live[idx] && off < slot_len[idx])
                begin
                    byte_seen[idx][off] = 1'b1;
                    if (off + 1 == slot_len[idx])
                        slot_primed[idx] = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                    slot_live[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // hand one beat over, with random idle cycles ahead of it
    task automatic send_request(input mcw_in_t beat);
        int idx;
        int off;
        idx = int'(beat.slot_id);
        off = int'(beat.byte_offset);
        // a primed slot must never compare against a shadow byte never written;
        // its last byte was written by the priming pass
        if (beat.opcode == OP_SAMPLE && idx < SLOTS && slot_live[idx]
            && slot_primed[idx] && off < slot_len[idx] && !byte_seen[idx][off])
            beat.byte_offset = 6'(slot_len[idx] - 1);
        track_request(beat);
        if (beat.opcode <= OP_CLEAR)
            counted_items++;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // stop sending until every predicted result beat has arrived
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // one full in-order pass over a region, half the time with a changed byte
    task automatic feed_pass(input int slot);
        mcw_in_t beat;
        int      spot;
        if ($urandom_range(0, 1) == 1)
        begin
            spot = $urandom_range(0, slot_len[slot] - 1);
            mem_image[slot][spot] = mem_image[slot][spot] ^ 8'($urandom_range(1, 255));
        end
        for (int off = 0; off < slot_len[slot]; off++)
        begin
            beat             = noise_beat(OP_SAMPLE);
            beat.slot_id     = 8'(slot);
            beat.byte_offset = 6'(off);
            beat.sample_byte = mem_image[slot][off];
            send_request(beat);
        end
    endtask

    initial
    begin
        mcw_in_t beat;
        int      pick;
        int      slot;
        int      phase;
        int      cur_phase;

        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        counted_items  = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_live[i]   = 1'b0;
            slot_primed[i] = 1'b0;
            slot_len[i]    = 0;
            for (int j = 0; j < WATCH_BYTES; j++)
            begin
                byte_seen[i][j] = 1'b0;
                mem_image[i][j] = 8'($urandom);
            end
        end

        // result side: ready with random stalls
        fork
            begin
                out_ch.ready = 1'b0;
                forever
                begin
                    @(posedge clk);
                    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
                end
            end
        join_none

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: refusals, priming, compare, lowest free slot, shared flag
        send_request(beat_of(OP_QUERY,  8'd0,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   32'h0, 8'd65,  6'd0,  8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   '1,    8'd255, 6'd0,  8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   '1,    8'd64,  6'd0,  8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   32'h0, 8'd1,   6'd0,  8'h00));
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd0,  8'hFF));
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd0,  8'hFF));
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd1,  8'h00));
        send_request(beat_of(OP_SAMPLE, 8'd255, 32'h0, 8'd0,   6'd63, 8'hFF));
        // lone last byte still closes a priming pass
        send_request(beat_of(OP_SAMPLE, 8'd0,   32'h0, 8'd0,   6'd63, 8'hA5));
        send_request(beat_of(OP_QUERY,  8'd1,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_REMOVE, 8'd1,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_REMOVE, 8'd1,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   32'h1234_5678, 8'd2, 6'd0, 8'h00));
        send_request(beat_of(OP_ADD,    8'd0,   32'h8765_4321, 8'd2, 6'd0, 8'h00));
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd1,  8'h11));
        send_request(beat_of(OP_SAMPLE, 8'd2,   32'h0, 8'd0,   6'd1,  8'h22));
        // interleaved: slot 1 differs, slot 2 closes first and takes the flag
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd0,  8'h5A));
        send_request(beat_of(OP_SAMPLE, 8'd2,   32'h0, 8'd0,   6'd1,  8'h22));
        send_request(beat_of(OP_SAMPLE, 8'd1,   32'h0, 8'd0,   6'd1,  8'h11));
        send_request(beat_of(3'd7,      8'd1,   '1,    8'd4,   6'd0,  8'h00));
        send_request(beat_of(OP_CLEAR,  8'd0,   32'h0, 8'd0,   6'd0,  8'h00));
        send_request(beat_of(OP_QUERY,  8'd2,   32'h0, 8'd0,   6'd0,  8'h00));

        // fill the empty table and try one add past full
        counted_items = 0;
        cur_phase     = 0;
        repeat (SLOTS + 1)
        begin
            beat               = noise_beat(OP_ADD);
            beat.region_length = 8'($urandom_range(1, 8));
            send_request(beat);
        end

        // random traffic, mostly complete passes
        while (counted_items < RANDOM_ITEMS)
        begin
            phase = counted_items * 4 / RANDOM_ITEMS;
            if (phase != cur_phase)
            begin
                wait_drained();
                cur_phase      = phase;
                send_idle_pct  = (phase == 1) ? 49 : (phase == 3) ? 8 : 0;
                recv_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 8 : 0;
            end
            pick = $urandom_range(0, 99);
            slot = pick_live_slot();
            if (pick < 55)
            begin
                if (slot < 0)
                begin
                    beat               = noise_beat(OP_ADD);
                    beat.region_length = 8'($urandom_range(1, 8));
                    send_request(beat);
                end
                else
                    feed_pass(slot);
            end
            else if (pick < 65)
            begin
                beat               = noise_beat(OP_ADD);
                beat.region_length = random_length();
                send_request(beat);
            end
            else if (pick < 81)
            begin
                beat = noise_beat((pick < 73) ? OP_REMOVE : OP_QUERY);
                if (slot >= 0 && $urandom_range(0, 3) != 0)
                    beat.slot_id = 8'(slot);
                send_request(beat);
            end
            else if (pick < 91)
            begin
                // stray sample byte, often on a live slot
                beat = noise_beat(OP_SAMPLE);
                if (slot >= 0 && $urandom_range(0, 3) != 0)
                begin
                    beat.slot_id     = 8'(slot);
                    beat.byte_offset = 6'($urandom_range(0, slot_len[slot] - 1));
                end
                send_request(beat);
            end
            else if (pick < 93)
                send_request(noise_beat(OP_CLEAR));
            else
                send_request(noise_beat(3'($urandom_range(5, 7))));
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("** memory_change_watch_table_unit: PASSED **");
        else
            $display("** memory_change_watch_table_unit: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/mcw_pkg.sv
sv/mcw_in_if.sv
sv/mcw_out_if.sv
sv/mcw_ram.sv
sv/mcw_free_find.sv
sv/memory_change_watch_table_unit.sv
test/mcw_watch_checker.sv
test/testbench.sv
